### rtl/core/fit_pkg.sv
// package for the frame index tracker: sizes, codes and state type
package fit_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  localparam logic [15:0] ECAT_ETHERTYPE = 16'h88A4;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_SET   = 2'd1,
    REQ_XMIT  = 2'd2,
    REQ_POLL  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_FOUND   = 2'd0,
    KIND_NOFRAME = 2'd1,
    KIND_OTHER   = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  localparam logic [2:0] ST_EMPTY = 3'd0;
  localparam logic [2:0] ST_ALLOC = 3'd1;
  localparam logic [2:0] ST_SENT  = 3'd2;
  localparam logic [2:0] ST_RCVD  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

endpackage

### rtl/core/frame_index_tracker.sv
// Order: a beat taken on start is captured with its slot memory reads into registers, executed
// in the execute state, and its result is registered and strobed on done.
// A new beat is taken only while not busy, so each beat's write-back ends before the next read.
// busy is high for the one execute cycle; results cannot be stalled by the receiver.
// Reset: all slots read as empty at once through per-slot valid flops, counters and the
// round-robin pointer clear; work counter and source word memories are not cleared.
module frame_index_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [3:0]  entry_index,
  input  logic [2:0]  status_value,
  input  logic        frame_present,
  input  logic [15:0] frame_ethertype,
  input  logic [7:0]  frame_index,
  input  logic [15:0] frame_wkc,
  input  logic [15:0] frame_source_word,
  output logic        done,
  output logic [1:0]  result_kind,
  output logic [15:0] work_count,
  output logic [3:0]  given_index,
  output logic        table_full,
  output logic [31:0] ecat_frames,
  output logic [31:0] dropped_frames
);
  import fit_pkg::*;

  // slot memories
  logic [2:0]  stat_mem [TABLE_DEPTH];
  logic [15:0] wkc_mem  [TABLE_DEPTH];
  logic [15:0] src_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] stat_vld;
  logic [TABLE_DEPTH-1:0] empty_map;

  fsm_t state, state_next;
  logic accept, exec_en;

  // captured beat
  req_t        q_req;
  logic [IDX_W-1:0] q_idx, q_fidx;
  logic        q_in_table, q_f_in_table, q_idx_match;
  logic [2:0]  q_sv;
  logic        q_present, q_is_ecat;
  logic [15:0] q_fwkc, q_fsrc;

  // read data
  logic [2:0]  rd_a, rd_b;
  logic        rd_a_vld, rd_b_vld;
  logic [15:0] rd_wkc;

  logic [IDX_W-1:0] last_given;
  logic [31:0] ecat_count, drop_count;

  // execute results
  logic        st_we;
  logic [IDX_W-1:0] st_wa;
  logic [2:0]  st_wd;
  logic        fr_we;
  logic [IDX_W-1:0] fr_wa;
  logic        lg_we;
  logic        inc_ecat, inc_drop;
  kind_t       kind;
  logic [15:0] wkc_out;
  logic [IDX_W-1:0] alloc_slot;
  logic        full_out;

  logic [2:0]  st_a, st_b;
  logic [IDX_W-1:0] rr_start;
  logic [IDX_W:0]   lg_inc, cand_sum;
  logic [IDX_W-1:0] cand;
  logic        found;

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: if (accept) state_next = FSM_EXEC;
      FSM_EXEC: state_next = FSM_IDLE;
      default:  state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state == FSM_EXEC);
    exec_en = (state == FSM_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the beat and issue the memory reads
  always_ff @(posedge clk) begin
    if (accept) begin
      q_req        <= req_t'(req_type);
      q_idx        <= IDX_W'(entry_index);
      q_fidx       <= IDX_W'(frame_index);
      q_in_table   <= ({1'b0, entry_index} < 5'(TABLE_DEPTH));
      q_f_in_table <= ({1'b0, frame_index} < 9'(TABLE_DEPTH));
      q_idx_match  <= ({4'b0, entry_index} == frame_index);
      q_sv         <= status_value;
      q_present    <= frame_present;
      q_is_ecat    <= (frame_ethertype == ECAT_ETHERTYPE);
      q_fwkc       <= frame_wkc;
      q_fsrc       <= frame_source_word;
      rd_a         <= stat_mem[IDX_W'(entry_index)];
      rd_a_vld     <= stat_vld[IDX_W'(entry_index)];
      rd_b         <= stat_mem[IDX_W'(frame_index)];
      rd_b_vld     <= stat_vld[IDX_W'(frame_index)];
      rd_wkc       <= wkc_mem[IDX_W'(entry_index)];
    end
  end

  assign st_a = rd_a_vld ? rd_a : ST_EMPTY;
  assign st_b = rd_b_vld ? rd_b : ST_EMPTY;

  // round-robin start: slot after the last one handed out
  always_comb begin
    lg_inc   = {1'b0, last_given} + (IDX_W + 1)'(1);
    rr_start = (lg_inc >= (IDX_W + 1)'(TABLE_DEPTH)) ? '0 : lg_inc[IDX_W-1:0];
  end

  // first empty slot at or after the start, wrapping
  always_comb begin
    found      = 1'b0;
    alloc_slot = rr_start;
    cand_sum   = '0;
    cand       = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      cand_sum = {1'b0, rr_start} + (IDX_W + 1)'(k);
      cand = (cand_sum >= (IDX_W + 1)'(TABLE_DEPTH)) ?
             IDX_W'(cand_sum - (IDX_W + 1)'(TABLE_DEPTH)) : cand_sum[IDX_W-1:0];
      if (empty_map[cand]) begin
        found      = 1'b1;
        alloc_slot = cand;
      end
    end
  end

  always_comb begin
    st_we    = 1'b0;
    st_wa    = q_idx;
    st_wd    = ST_DONE;
    fr_we    = 1'b0;
    fr_wa    = q_idx;
    lg_we    = 1'b0;
    inc_ecat = 1'b0;
    inc_drop = 1'b0;
    kind     = KIND_DONE;
    wkc_out  = '0;
    full_out = 1'b0;
    unique case (q_req)
      REQ_ALLOC: begin
        st_we    = 1'b1;
        st_wa    = alloc_slot;
        st_wd    = ST_ALLOC;
        lg_we    = 1'b1;
        full_out = !found;
      end
      REQ_SET: begin
        st_we = q_in_table;
        st_wd = q_sv;
      end
      REQ_XMIT: begin
        st_we = q_in_table;
        st_wd = ST_SENT;
      end
      REQ_POLL: begin
        priority if (q_in_table && st_a == ST_RCVD) begin
          kind    = KIND_FOUND;
          wkc_out = rd_wkc;
          st_we   = 1'b1;
        end else if (!q_present) begin
          kind = KIND_NOFRAME;
        end else if (q_is_ecat) begin
          kind     = KIND_OTHER;
          inc_ecat = 1'b1;
          if (q_idx_match) begin
            if (q_in_table) begin
              kind    = KIND_FOUND;
              wkc_out = q_fwkc;
              st_we   = 1'b1;
              fr_we   = 1'b1;
            end
          end else if (q_f_in_table && st_b == ST_SENT) begin
            // frame for another sent slot: park it
            st_we = 1'b1;
            st_wa = q_fidx;
            st_wd = ST_RCVD;
            fr_we = 1'b1;
            fr_wa = q_fidx;
          end
        end else begin
          kind     = KIND_OTHER;
          inc_drop = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // write back
  always_ff @(posedge clk) begin
    if (exec_en && st_we) begin
      stat_mem[st_wa] <= st_wd;
    end
    if (exec_en && fr_we) begin
      wkc_mem[fr_wa] <= q_fwkc;
      src_mem[fr_wa] <= q_fsrc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat_vld   <= '0;
      empty_map  <= '1;
      last_given <= '0;
      ecat_count <= '0;
      drop_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= exec_en;
      if (exec_en && st_we) begin
        stat_vld[st_wa]  <= 1'b1;
        empty_map[st_wa] <= (st_wd == ST_EMPTY);
      end
      if (exec_en && lg_we) last_given <= alloc_slot;
      if (exec_en && inc_ecat) ecat_count <= ecat_count + 32'd1;
      if (exec_en && inc_drop) drop_count <= drop_count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      result_kind <= kind;
      work_count  <= wkc_out;
      given_index <= (q_req == REQ_ALLOC) ? 4'(alloc_slot) : 4'd0;
      table_full  <= full_out;
    end
  end

  assign ecat_frames    = ecat_count;
  assign dropped_frames = drop_count;

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("execute cycle did not end");

  a_accept_execs: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted beat not executed");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without execute cycle");

  a_alloc_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result_kind != KIND_DONE) |-> (given_index == 4'd0 && !table_full))
    else $error("allocate fields set on a poll result");

  a_counts_move_on_result: assert property (@(posedge clk) disable iff (rst)
    (ecat_frames != $past(ecat_frames) || dropped_frames != $past(dropped_frames))
      |-> done)
    else $error("frame counters moved without a result");

endmodule

### verif/frame_index_tracker_test.sv
`timescale 1ns / 100ps
// testbench for the frame index tracker: directed and random table requests against a predictor
module frame_index_tracker_test;
  import fit_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    req_t        req;
    logic [3:0]  idx;
    logic [2:0]  sv;
    logic        present;
    logic [15:0] etype;
    logic [7:0]  fidx;
    logic [15:0] fwkc;
    logic [15:0] fsrc;
  } slot_request_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] wkc;
    logic [3:0]  given;
    logic        full;
    logic [31:0] ecat;
    logic [31:0] drop;
  } slot_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [3:0]  entry_index;
  logic [2:0]  status_value;
  logic        frame_present;
  logic [15:0] frame_ethertype;
  logic [7:0]  frame_index;
  logic [15:0] frame_wkc;
  logic [15:0] frame_source_word;
  logic        done;
  logic [1:0]  result_kind;
  logic [15:0] work_count;
  logic [3:0]  given_index;
  logic        table_full;
  logic [31:0] ecat_frames;
  logic [31:0] dropped_frames;

  // predicted table state
  logic [2:0]  slot_st [TABLE_DEPTH];
  logic [15:0] slot_wkc_m [TABLE_DEPTH];
  bit          wkc_known [TABLE_DEPTH];
  int          rr_last;
  logic [31:0] ecat_cnt;
  logic [31:0] drop_cnt;

  slot_result_t pending_results[$];

  int  error_count;
  int  n_beats;
  int  n_full;
  int  n_found;
  int  cycle_count;
  bit  idle_on;

  frame_index_tracker u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .req_type         (req_type),
    .entry_index      (entry_index),
    .status_value     (status_value),
    .frame_present    (frame_present),
    .frame_ethertype  (frame_ethertype),
    .frame_index      (frame_index),
    .frame_wkc        (frame_wkc),
    .frame_source_word(frame_source_word),
    .done             (done),
    .result_kind      (result_kind),
    .work_count       (work_count),
    .given_index      (given_index),
    .table_full       (table_full),
    .ecat_frames      (ecat_frames),
    .dropped_frames   (dropped_frames)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    error_count++;
    if (error_count <= 20)
      $display("mismatch at beat result %s: got %h expected %h (t=%0t)", what, got, exp, $time);
  endtask

  // one table operation, updates the predicted state and returns the expected result
  function automatic slot_result_t track_slots(input slot_request_t r);
    slot_result_t res;
    int           first;
    int           s;
    int           cnt;
    int           i;
    int           f;
    res.kind  = KIND_DONE;
    res.wkc   = '0;
    res.given = '0;
    res.full  = 1'b0;
    i = int'(r.idx);
    f = int'(r.fidx);
    case (r.req)
      REQ_ALLOC: begin
        first = (rr_last + 1) % TABLE_DEPTH;
        s = first;
        cnt = 0;
        while (slot_st[s] != ST_EMPTY && cnt < TABLE_DEPTH) begin
          s = (s + 1) % TABLE_DEPTH;
          cnt++;
        end
        if (cnt >= TABLE_DEPTH) begin
          s = first;
          res.full = 1'b1;
        end
        slot_st[s] = ST_ALLOC;
        rr_last = s;
        res.given = s[3:0];
      end
      REQ_SET: begin
        if (i < TABLE_DEPTH) slot_st[i] = r.sv;
      end
      REQ_XMIT: begin
        if (i < TABLE_DEPTH) slot_st[i] = ST_SENT;
      end
      default: begin
        if (i < TABLE_DEPTH && slot_st[i] == ST_RCVD) begin
          // a parked frame wins over anything arriving now
          res.kind = KIND_FOUND;
          res.wkc = slot_wkc_m[i];
          slot_st[i] = ST_DONE;
        end else if (!r.present) begin
          res.kind = KIND_NOFRAME;
        end else begin
          res.kind = KIND_OTHER;
          if (r.etype == ECAT_ETHERTYPE) begin
            ecat_cnt++;
            if (f == i) begin
              if (i < TABLE_DEPTH) begin
                res.kind = KIND_FOUND;
                res.wkc = r.fwkc;
                slot_wkc_m[i] = r.fwkc;
                wkc_known[i] = 1'b1;
                slot_st[i] = ST_DONE;
              end
            end else if (f < TABLE_DEPTH && slot_st[f] == ST_SENT) begin
              slot_wkc_m[f] = r.fwkc;
              wkc_known[f] = 1'b1;
              slot_st[f] = ST_RCVD;
            end
          end else begin
            drop_cnt++;
          end
        end
      end
    endcase
    res.ecat = ecat_cnt;
    res.drop = drop_cnt;
    return res;
  endfunction

  function automatic slot_request_t make_beat(input req_t req, input int idx, input int sv,
                                              input bit present, input logic [15:0] etype,
                                              input int fidx, input logic [15:0] fwkc,
                                              input logic [15:0] fsrc);
    slot_request_t r;
    r.req = req;
    r.idx = idx[3:0];
    r.sv = sv[2:0];
    r.present = present;
    r.etype = etype;
    r.fidx = fidx[7:0];
    r.fwkc = fwkc;
    r.fsrc = fsrc;
    return r;
  endfunction

  function automatic slot_request_t random_beat();
    slot_request_t r;
    r.req = req_t'($urandom_range(0, 3));
    r.idx = 4'($urandom_range(0, 15));
    r.sv = 3'($urandom_range(0, 7));
    r.present = 1'($urandom_range(0, 1));
    r.etype = ($urandom_range(0, 1) == 1) ? ECAT_ETHERTYPE : 16'($urandom_range(0, 65535));
    r.fidx = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    r.fwkc = 16'($urandom_range(0, 65535));
    r.fsrc = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  // called at a rising edge; leaves start high unless an idle gap follows
  task automatic issue_request(input slot_request_t r);
    slot_request_t v;
    slot_result_t  e;
    v = r;
    // never mark a slot received when no frame has ever stored its work counter
    if (v.req == REQ_SET && v.sv == ST_RCVD && !wkc_known[v.idx]) v.sv = ST_SENT;
    req_type <= v.req;
    entry_index <= v.idx;
    status_value <= v.sv;
    frame_present <= v.present;
    frame_ethertype <= v.etype;
    frame_index <= v.fidx;
    frame_wkc <= v.fwkc;
    frame_source_word <= v.fsrc;
    start <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    e = track_slots(v);
    pending_results.push_back(e);
    n_beats++;
    if (e.full) n_full++;
    if (e.kind == KIND_FOUND) n_found++;
    if (idle_on && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_results_settled();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_result
    slot_result_t e;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("with nothing expected", {30'd0, result_kind}, 32'd0);
      end else begin
        e = pending_results.pop_front();
        if (result_kind !== e.kind)
          report_mismatch("result_kind", 32'(result_kind), 32'(e.kind));
        if (work_count !== e.wkc)
          report_mismatch("work_count", 32'(work_count), 32'(e.wkc));
        if (given_index !== e.given)
          report_mismatch("given_index", 32'(given_index), 32'(e.given));
        if (table_full !== e.full)
          report_mismatch("table_full", 32'(table_full), 32'(e.full));
        if (ecat_frames !== e.ecat) report_mismatch("ecat_frames", ecat_frames, e.ecat);
        if (dropped_frames !== e.drop)
          report_mismatch("dropped_frames", dropped_frames, e.drop);
      end
    end
  end

  task automatic test_alloc_and_status();
    issue_request(make_beat(REQ_ALLOC, 0, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000));
    issue_request(make_beat(REQ_ALLOC, 15, 7, 1, 16'hFFFF, 255, 16'hFFFF, 16'hFFFF));
    // unnamed status codes are stored as written
    issue_request(make_beat(REQ_SET, 5, 5, 0, 16'h0000, 0, 16'h0000, 16'h0000));
    issue_request(make_beat(REQ_SET, 6, 6, 0, 16'h0000, 0, 16'h0000, 16'h0000));
    issue_request(make_beat(REQ_SET, 7, 7, 0, 16'h0000, 0, 16'h0000, 16'h0000));
    issue_request(make_beat(REQ_SET, 4, int'(ST_DONE), 0, 16'h0000, 0, 16'h0000, 16'h0000));
    issue_request(make_beat(REQ_SET, 3, int'(ST_ALLOC), 0, 16'h0000, 0, 16'h0000, 16'h0000));
    issue_request(make_beat(REQ_SET, 3, int'(ST_EMPTY), 0, 16'h0000, 0, 16'h0000, 16'h0000));
  endtask

  task automatic test_frame_matching();
    issue_request(make_beat(REQ_XMIT, 1, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000));
    issue_request(make_beat(REQ_POLL, 1, 0, 1, ECAT_ETHERTYPE, 1, 16'hFFFF, 16'hFFFF));
    issue_request(make_beat(REQ_XMIT, 2, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000));
    issue_request(make_beat(REQ_XMIT, 15, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000));
    // frame for another sent slot gets parked there
    issue_request(make_beat(REQ_POLL, 2, 0, 1, ECAT_ETHERTYPE, 15, 16'h0000, 16'h0000));
    // parked frame is collected, the arriving one ignored
    issue_request(make_beat(REQ_POLL, 15, 0, 1, ECAT_ETHERTYPE, 15, 16'h1234, 16'h5678));
    issue_request(make_beat(REQ_POLL, 2, 0, 1, 16'h0000, 2, 16'hBEEF, 16'h0000));
    issue_request(make_beat(REQ_POLL, 2, 0, 1, 16'hFFFF, 2, 16'hBEEF, 16'hFFFF));
    issue_request(make_beat(REQ_POLL, 2, 7, 0, 16'hFFFF, 255, 16'hFFFF, 16'hFFFF));
    // frame indexes beyond the table count but land nowhere
    issue_request(make_beat(REQ_POLL, 2, 0, 1, ECAT_ETHERTYPE, 255, 16'h4444, 16'h0000));
    issue_request(make_beat(REQ_POLL, 2, 0, 1, ECAT_ETHERTYPE, 16, 16'h5555, 16'h0000));
    // matching frame completes a slot whatever its status, unless a parked frame is waiting
    issue_request(make_beat(REQ_POLL, 7, 0, 1, ECAT_ETHERTYPE, 7, 16'hA5A5, 16'h5A5A));
    issue_request(make_beat(REQ_POLL, 3, 0, 1, ECAT_ETHERTYPE, 5, 16'h7777, 16'h0000));
    issue_request(make_beat(REQ_SET, 15, int'(ST_RCVD), 0, 16'h0000, 0, 16'h0000, 16'h0000));
    issue_request(make_beat(REQ_POLL, 15, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000));
  endtask

  task automatic test_table_full();
    bit empty_left;
    empty_left = 1'b1;
    while (empty_left) begin
      issue_request(make_beat(REQ_ALLOC, 0, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000));
      empty_left = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (slot_st[i] == ST_EMPTY) empty_left = 1'b1;
    end
    issue_request(make_beat(REQ_ALLOC, 9, 3, 1, ECAT_ETHERTYPE, 9, 16'h0001, 16'h0001));
    issue_request(make_beat(REQ_ALLOC, 0, 0, 0, 16'h0000, 0, 16'h0000, 16'h0000));
  endtask

  // allocate, send, then collect the answer in one of several orders or leave it outstanding
  task automatic run_exchange();
    slot_request_t r;
    int            s;
    int            other;
    r = random_beat();
    r.req = REQ_ALLOC;
    issue_request(r);
    s = rr_last;
    r = random_beat();
    r.req = REQ_XMIT;
    r.idx = s[3:0];
    issue_request(r);
    case ($urandom_range(0, 3))
      0: begin
        issue_request(make_beat(REQ_POLL, s, $urandom_range(0, 7), 1, ECAT_ETHERTYPE, s,
                                16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535))));
      end
      1: begin
        other = (s + $urandom_range(1, TABLE_DEPTH - 1)) % TABLE_DEPTH;
        issue_request(make_beat(REQ_POLL, other, 0, 1, ECAT_ETHERTYPE, s,
                                16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535))));
        r = random_beat();
        r.req = REQ_POLL;
        r.idx = s[3:0];
        issue_request(r);
      end
      2: begin
        issue_request(make_beat(REQ_POLL, s, 0, 0, 16'($urandom_range(0, 65535)), s, 0, 0));
        issue_request(make_beat(REQ_POLL, s, 0, 1, ECAT_ETHERTYPE, s,
                                16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535))));
      end
      default: ;  // leave it outstanding
    endcase
    if ($urandom_range(0, 1) == 1)
      issue_request(make_beat(REQ_SET, s, int'(ST_EMPTY), 0, 16'h0000, 0, 16'h0000, 16'h0000));
  endtask

  task automatic test_random_traffic(input int beat_target);
    while (n_beats < beat_target) begin
      if ($urandom_range(0, 99) < 70) run_exchange();
      else issue_request(random_beat());
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req_type = '0;
    entry_index = '0;
    status_value = '0;
    frame_present = 1'b0;
    frame_ethertype = '0;
    frame_index = '0;
    frame_wkc = '0;
    frame_source_word = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_st[i] = ST_EMPTY;
      slot_wkc_m[i] = '0;
      wkc_known[i] = 1'b0;
    end
    rr_last = 0;
    ecat_cnt = '0;
    drop_cnt = '0;
    error_count = 0;
    n_beats = 0;
    n_full = 0;
    n_found = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_alloc_and_status();
    test_frame_matching();
    wait_results_settled();
    test_table_full();
    test_random_traffic(n_beats + 300);
    wait_results_settled();
    // back-to-back stretch
    idle_on = 1'b0;
    test_random_traffic(n_beats + 150);
    idle_on = 1'b1;
    test_random_traffic(n_beats + 150);

    wait_results_settled();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("left outstanding", pending_results.size(), 32'd0);
    $display("ran %0d table requests: %0d allocations on a full table, %0d work counters",
             n_beats, n_full, n_found);
    $display("collected, %0d EtherCAT frames seen and %0d frames dropped", ecat_cnt, drop_cnt);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/fit_pkg.sv
rtl/core/frame_index_tracker.sv
verif/frame_index_tracker_test.sv
